[design/iac_pkg.sv]
// Shared types, codes and reset constants for the intrusion alarm controller.
package iac_pkg;

  localparam int unsigned CfgDataWidth = 24;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [15:0] ArmBlinkHalfReset = 16'd400;
  localparam logic [7:0] ArmBlinkCountReset = 8'd10;
  localparam logic [23:0] TriggerWindowReset = 24'd10000;
  localparam logic [15:0] FlashPeriodReset = 16'd1000;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_ARM_BLINK_HALF  = 2'd0,
    CFG_ARM_BLINK_COUNT = 2'd1,
    CFG_TRIGGER_WINDOW  = 2'd2,
    CFG_FLASH_PERIOD    = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_ARMING    = 3'd1,
    MODE_ARMED     = 3'd2,
    MODE_TRIGGERED = 3'd3,
    MODE_SOUNDING  = 3'd4
  } mode_t;

  typedef struct packed {
    logic buzzer;
    logic red;
    logic blue;
  } lamp_t;

  localparam lamp_t LampsOff = '{buzzer: 1'b0, red: 1'b0, blue: 1'b1};
  localparam lamp_t LampsArmed = '{buzzer: 1'b0, red: 1'b1, blue: 1'b0};
  localparam lamp_t LampsAllOn = '{buzzer: 1'b1, red: 1'b1, blue: 1'b1};
  localparam lamp_t LampsDark = '{buzzer: 1'b0, red: 1'b0, blue: 1'b0};

  typedef struct packed {
    logic [15:0] arm_blink_half_ticks;
    logic [7:0]  arm_blink_count;
    logic [23:0] trigger_window_ticks;
    logic [15:0] flash_period_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    lamp_t lamps;
    logic  notify;
  } result_t;

endpackage

[design/iac_if.sv]
// Valid/ready channel interfaces for tick requests and result requests.
interface iac_tick_if;
  logic valid;
  logic ready;
  logic button_pressed;
  logic motion_seen;

  modport source (output valid, output button_pressed, output motion_seen, input ready);
  modport sink (input valid, input button_pressed, input motion_seen, output ready);
endinterface

interface iac_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       blue_lamp;
  logic       red_lamp;
  logic       buzzer_on;
  logic       notify;

  modport source (output valid, output mode, output blue_lamp, output red_lamp,
                  output buzzer_on, output notify, input ready);
  modport sink (input valid, input mode, input blue_lamp, input red_lamp,
                input buzzer_on, input notify, output ready);
endinterface

[design/iac_cfg_regs.sv]
// Configuration register file for the alarm timing values.
module iac_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [iac_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [iac_pkg::CfgDataWidth-1:0]    cfg_data,
  output iac_pkg::cfg_t                       cfg
);
  import iac_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_blink_half_ticks <= ArmBlinkHalfReset;
      cfg.arm_blink_count <= ArmBlinkCountReset;
      cfg.trigger_window_ticks <= TriggerWindowReset;
      cfg.flash_period_ticks <= FlashPeriodReset;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ARM_BLINK_HALF:  cfg.arm_blink_half_ticks <= cfg_data[15:0];
        CFG_ARM_BLINK_COUNT: cfg.arm_blink_count <= cfg_data[7:0];
        CFG_TRIGGER_WINDOW:  cfg.trigger_window_ticks <= cfg_data[23:0];
        CFG_FLASH_PERIOD:    cfg.flash_period_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

[design/iac_step.sv]
// Mode state machine and tick counters; gives the result of the tick being taken.
module iac_step (
  input  logic             clk,
  input  logic             rst,
  input  iac_pkg::cfg_t    cfg,
  input  logic             step_en,
  input  logic             button,
  input  logic             motion,
  output iac_pkg::result_t res
);
  import iac_pkg::*;

  mode_t       mode_q, mode_next;
  logic [23:0] tick_count, tick_count_next;
  logic [15:0] phase_count, phase_count_next;
  logic [8:0]  blinks_done, blinks_done_next;
  logic        flash_phase, flash_phase_next;
  lamp_t       lamps, lamps_next;
  logic        notify_next;

  logic [15:0] blink_half_eff, flash_eff;
  logic [7:0]  blink_count_eff;
  logic [23:0] window_eff;
  logic [16:0] phase_inc;
  logic [8:0]  blinks_inc;
  logic [23:0] tick_inc;
  logic        blink_end, flash_end;

  // A zero register value behaves as one.
  assign blink_half_eff = (cfg.arm_blink_half_ticks == '0) ? 16'd1 : cfg.arm_blink_half_ticks;
  assign flash_eff = (cfg.flash_period_ticks == '0) ? 16'd1 : cfg.flash_period_ticks;
  assign blink_count_eff = (cfg.arm_blink_count == '0) ? 8'd1 : cfg.arm_blink_count;
  assign window_eff = (cfg.trigger_window_ticks == '0) ? 24'd1 : cfg.trigger_window_ticks;

  assign phase_inc = {1'b0, phase_count} + 17'd1;
  assign blink_end = phase_inc >= {1'b0, blink_half_eff};
  assign flash_end = phase_inc >= {1'b0, flash_eff};
  assign blinks_inc = blinks_done + 9'd1;
  assign tick_inc = tick_count + 24'd1;

  always_comb begin
    mode_next = mode_q;
    tick_count_next = tick_count;
    phase_count_next = phase_count;
    blinks_done_next = blinks_done;
    flash_phase_next = flash_phase;
    lamps_next = lamps;
    notify_next = 1'b0;

    unique case (mode_q)
      MODE_ARMING: begin
        if (blink_end) begin
          phase_count_next = '0;
          if (lamps.blue) begin
            lamps_next.blue = 1'b0;
          end else if (blinks_inc >= {1'b0, blink_count_eff}) begin
            mode_next = MODE_ARMED;
            lamps_next = LampsArmed;
            blinks_done_next = '0;
          end else begin
            blinks_done_next = blinks_inc;
            lamps_next.blue = 1'b1;
          end
        end else begin
          phase_count_next = phase_inc[15:0];
        end
      end
      MODE_ARMED: begin
        if (button) begin
          mode_next = MODE_OFF;
          lamps_next = LampsOff;
          tick_count_next = '0;
          phase_count_next = '0;
          blinks_done_next = '0;
          flash_phase_next = 1'b0;
        end else if (motion) begin
          mode_next = MODE_TRIGGERED;
          tick_count_next = '0;
          phase_count_next = '0;
          flash_phase_next = 1'b0;
        end
      end
      MODE_TRIGGERED, MODE_SOUNDING: begin
        if (button) begin
          mode_next = MODE_OFF;
          lamps_next = LampsOff;
          tick_count_next = '0;
          phase_count_next = '0;
          blinks_done_next = '0;
          flash_phase_next = 1'b0;
        end else begin
          if (flash_end) begin
            phase_count_next = '0;
            flash_phase_next = ~flash_phase;
            if (mode_q == MODE_SOUNDING) begin
              lamps_next = flash_phase ? LampsDark : LampsAllOn;
            end else begin
              lamps_next.blue = ~flash_phase;
              lamps_next.red = ~flash_phase;
            end
          end else begin
            phase_count_next = phase_inc[15:0];
          end
          if (mode_q == MODE_TRIGGERED) begin
            tick_count_next = tick_inc;
            // Window over (or counter wrapped): start sounding with outputs due to go dark.
            if (tick_inc == '0 || tick_inc >= window_eff) begin
              mode_next = MODE_SOUNDING;
              notify_next = 1'b1;
              tick_count_next = '0;
              phase_count_next = '0;
              flash_phase_next = 1'b1;
            end
          end
        end
      end
      default: begin
        // Off, and any unused code, settles to off, or to arming when the button is pressed.
        mode_next = button ? MODE_ARMING : MODE_OFF;
        lamps_next = LampsOff;
        tick_count_next = '0;
        phase_count_next = '0;
        blinks_done_next = '0;
        flash_phase_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= MODE_OFF;
      tick_count <= '0;
      phase_count <= '0;
      blinks_done <= '0;
      flash_phase <= 1'b0;
      lamps <= LampsOff;
    end else if (step_en) begin
      mode_q <= mode_next;
      tick_count <= tick_count_next;
      phase_count <= phase_count_next;
      blinks_done <= blinks_done_next;
      flash_phase <= flash_phase_next;
      lamps <= lamps_next;
    end
  end

  assign res.mode = mode_next;
  assign res.lamps = lamps_next;
  assign res.notify = notify_next;

  a_off_lamps: assert property (@(posedge clk) disable iff (rst)
    mode_q == MODE_OFF |-> lamps == LampsOff)
    else $error("off mode with lamps other than blue");
  a_armed_lamps: assert property (@(posedge clk) disable iff (rst)
    mode_q == MODE_ARMED |-> lamps == LampsArmed)
    else $error("armed mode with lamps other than red");
  a_button_cancels: assert property (@(posedge clk) disable iff (rst)
    step_en && button && (mode_q == MODE_TRIGGERED || mode_q == MODE_SOUNDING ||
    mode_q == MODE_ARMED) |=> mode_q == MODE_OFF)
    else $error("button did not return to off");
  a_notify_entry: assert property (@(posedge clk) disable iff (rst)
    res.notify |-> mode_q == MODE_TRIGGERED && res.mode == MODE_SOUNDING)
    else $error("notify outside entry to sounding");

endmodule

[design/intrusion_alarm_controller_top.sv]
// Top level of the intrusion alarm controller: config port, step logic, result register.
//
//   channel  dir  fields
//   tick     in   button_pressed, motion_seen
//   result   out  mode, blue_lamp, red_lamp, buzzer_on, notify
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One tick request is taken per cycle unless stalled; its result appears in the result register
// on the next cycle, set by the single state update between the state and result registers.
// Reset (synchronous rst) clears the mode to off with the blue lamp on and loads default timing.
// A stalled result holds its register; a new tick is still taken if that result
// leaves in the same cycle.
module intrusion_alarm_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [iac_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [iac_pkg::CfgDataWidth-1:0]  cfg_data,
  iac_tick_if.sink                          tick,
  iac_result_if.source                      result
);
  import iac_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    out_valid;
  logic    accept;

  assign tick.ready = !out_valid || result.ready;
  assign accept = tick.valid && tick.ready;

  iac_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iac_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (accept),
    .button  (tick.button_pressed),
    .motion  (tick.motion_seen),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      res_q <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.mode = res_q.mode;
  assign result.blue_lamp = res_q.lamps.blue;
  assign result.red_lamp = res_q.lamps.red;
  assign result.buzzer_on = res_q.lamps.buzzer;
  assign result.notify = res_q.notify;

endmodule

[bench/tb_intrusion_alarm_controller_top.sv]
// Testbench for the intrusion alarm controller: directed and random tick streams checked against a local model.
module tb_intrusion_alarm_controller_top;
  import iac_pkg::*;

  localparam int unsigned WatchdogLimit = 1500;
  localparam int unsigned PressureAt = 250;
  localparam int unsigned PressureHold = 80;

  typedef struct packed {
    logic button;
    logic motion;
  } tick_req_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  cfg_index_t               cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  iac_tick_if   tick_ch ();
  iac_result_if result_ch ();

  intrusion_alarm_controller_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  always #4 clk = ~clk;

  // Alarm model state and timing copy
  cfg_t         timing;
  mode_t        alarm_mode;
  logic [23:0]  window_ticks;
  logic [15:0]  phase_ticks;
  logic [8:0]   blinks;
  logic         flash_off_next;
  lamp_t        lamps;

  tick_req_t    pending_ticks[$];
  result_t      pending_results[$];
  int unsigned  n_queued = 0;
  int unsigned  n_taken = 0;
  int unsigned  n_checked = 0;
  int unsigned  mismatches = 0;
  int unsigned  send_gap = 0;
  int unsigned  stall_left = 0;
  int unsigned  hold_left = 0;
  bit           pressure_done = 1'b0;
  bit           steady = 1'b0;
  int unsigned  idle_cycles = 0;

  function automatic void enter_off();
    alarm_mode = MODE_OFF;
    lamps = LampsOff;
    window_ticks = '0;
    phase_ticks = '0;
    blinks = '0;
    flash_off_next = 1'b0;
  endfunction

  function automatic void alarm_reset();
    timing.arm_blink_half_ticks = ArmBlinkHalfReset;
    timing.arm_blink_count = ArmBlinkCountReset;
    timing.trigger_window_ticks = TriggerWindowReset;
    timing.flash_period_ticks = FlashPeriodReset;
    enter_off();
  endfunction

  // Advance the phase counter; a zero length acts as one.
  function automatic bit phase_over(logic [15:0] len);
    logic [16:0] nxt;
    logic [15:0] lim;
    lim = (len == '0) ? 16'd1 : len;
    nxt = {1'b0, phase_ticks} + 17'd1;
    if (nxt >= {1'b0, lim}) begin
      phase_ticks = '0;
      return 1'b1;
    end
    phase_ticks = nxt[15:0];
    return 1'b0;
  endfunction

  function automatic result_t alarm_step(logic button, logic motion);
    result_t r;
    logic    pulse;
    logic [7:0]  count_lim;
    logic [23:0] window_lim;
    pulse = 1'b0;
    count_lim = (timing.arm_blink_count == '0) ? 8'd1 : timing.arm_blink_count;
    window_lim = (timing.trigger_window_ticks == '0) ? 24'd1 : timing.trigger_window_ticks;
    case (alarm_mode)
      MODE_ARMING: begin
        if (phase_over(timing.arm_blink_half_ticks)) begin
          if (lamps.blue) begin
            lamps.blue = 1'b0;
          end else begin
            blinks = blinks + 9'd1;
            if (blinks >= {1'b0, count_lim}) begin
              alarm_mode = MODE_ARMED;
              lamps = LampsArmed;
              blinks = '0;
            end else begin
              lamps.blue = 1'b1;
            end
          end
        end
      end
      MODE_ARMED: begin
        if (button) begin
          enter_off();
        end else if (motion) begin
          alarm_mode = MODE_TRIGGERED;
          window_ticks = '0;
          phase_ticks = '0;
          flash_off_next = 1'b0;
        end
      end
      MODE_TRIGGERED: begin
        if (button) begin
          enter_off();
        end else begin
          if (phase_over(timing.flash_period_ticks)) begin
            lamps.blue = ~flash_off_next;
            lamps.red = ~flash_off_next;
            flash_off_next = ~flash_off_next;
          end
          window_ticks = window_ticks + 24'd1;
          if (window_ticks == '0 || window_ticks >= window_lim) begin
            alarm_mode = MODE_SOUNDING;
            pulse = 1'b1;
            window_ticks = '0;
            phase_ticks = '0;
            flash_off_next = 1'b1;
          end
        end
      end
      MODE_SOUNDING: begin
        if (button) begin
          enter_off();
        end else if (phase_over(timing.flash_period_ticks)) begin
          lamps = flash_off_next ? LampsDark : LampsAllOn;
          flash_off_next = ~flash_off_next;
        end
      end
      default: begin
        enter_off();
        if (button) begin
          alarm_mode = MODE_ARMING;
          lamps = LampsOff;
        end
      end
    endcase
    r.mode = alarm_mode;
    r.lamps = lamps;
    r.notify = pulse;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Request driver
  always @(posedge clk) begin
    tick_req_t nxt;
    if (rst) begin
      tick_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        pending_results.push_back(alarm_step(tick_ch.button_pressed, tick_ch.motion_seen));
        n_taken++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          tick_ch.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          tick_ch.valid <= 1'b1;
          tick_ch.button_pressed <= nxt.button;
          tick_ch.motion_seen <= nxt.motion;
          send_gap <= steady ? 0 : gap_len();
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!pressure_done && n_taken >= PressureAt) begin
      pressure_done <= 1'b1;
      hold_left <= PressureHold;
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left <= gap_len();
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no tick pending: mode %0d", result_ch.mode);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, result_ch.mode);
          mismatches++;
        end
        if (result_ch.blue_lamp !== want.lamps.blue) begin
          $error("blue_lamp: expected %0b, got %0b", want.lamps.blue, result_ch.blue_lamp);
          mismatches++;
        end
        if (result_ch.red_lamp !== want.lamps.red) begin
          $error("red_lamp: expected %0b, got %0b", want.lamps.red, result_ch.red_lamp);
          mismatches++;
        end
        if (result_ch.buzzer_on !== want.lamps.buzzer) begin
          $error("buzzer_on: expected %0b, got %0b", want.lamps.buzzer, result_ch.buzzer_on);
          mismatches++;
        end
        if (result_ch.notify !== want.notify) begin
          $error("notify: expected %0b, got %0b", want.notify, result_ch.notify);
          mismatches++;
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_tick(logic button, logic motion);
    pending_ticks.push_back('{button: button, motion: motion});
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_checked != n_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Fill the unused upper data bits with noise; the register keeps only its width.
  task automatic write_reg(cfg_index_t idx, logic [23:0] value);
    logic [23:0] data;
    data = value;
    case (idx)
      CFG_ARM_BLINK_HALF: begin
        data[23:16] = 8'($urandom_range(0, 255));
        timing.arm_blink_half_ticks = value[15:0];
      end
      CFG_ARM_BLINK_COUNT: begin
        data[23:8] = 16'($urandom_range(0, 65535));
        timing.arm_blink_count = value[7:0];
      end
      CFG_TRIGGER_WINDOW: begin
        timing.trigger_window_ticks = value;
      end
      default: begin
        data[23:16] = 8'($urandom_range(0, 255));
        timing.flash_period_ticks = value[15:0];
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic set_timing(logic [15:0] half, logic [7:0] count, logic [23:0] window,
                            logic [15:0] flash);
    write_reg(CFG_ARM_BLINK_HALF, {8'd0, half});
    write_reg(CFG_ARM_BLINK_COUNT, {16'd0, count});
    write_reg(CFG_TRIGGER_WINDOW, window);
    write_reg(CFG_FLASH_PERIOD, {8'd0, flash});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly quiet buttons so the alarm gets through arming into triggered and sounding.
  task automatic random_ticks(int unsigned count, int unsigned button_pct);
    for (int unsigned k = 0; k < count; k++) begin
      queue_tick($urandom_range(0, 99) < button_pct, $urandom_range(0, 99) < 35);
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_ARM_BLINK_HALF;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.button_pressed = 1'b0;
    tick_ch.motion_seen = 1'b0;
    result_ch.ready = 1'b0;
    alarm_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: off ignores motion, button arms, arming ignores the button
    queue_tick(0, 0); queue_tick(0, 1); queue_tick(1, 1);
    queue_tick(1, 0); queue_tick(1, 1); queue_tick(0, 0);
    wait_drained();

    // Zero registers act as one: walk every mode one tick at a time
    set_timing(16'd0, 8'd0, 24'd0, 16'd0);
    queue_tick(0, 0); queue_tick(0, 0);
    queue_tick(1, 1);
    queue_tick(1, 0); queue_tick(0, 0); queue_tick(0, 0);
    queue_tick(0, 1); queue_tick(0, 0); queue_tick(0, 1); queue_tick(0, 0);
    queue_tick(1, 1);
    queue_tick(1, 0); queue_tick(0, 1); queue_tick(0, 1); queue_tick(0, 1);
    queue_tick(1, 1);
    wait_drained();

    set_timing(16'd1, 8'd1, 24'd1, 16'd1);
    random_ticks(80, 6);

    steady = 1'b1;
    set_timing(16'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
               24'($urandom_range(1, 12)), 16'($urandom_range(1, 5)));
    random_ticks(90, 6);
    steady = 1'b0;

    set_timing(16'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
               24'($urandom_range(1, 12)), 16'($urandom_range(1, 5)));
    random_ticks(90, 6);

    set_timing(16'hFFFF, 8'hFF, 24'hFFFFFF, 16'hFFFF);
    random_ticks(40, 10);

    // Noisy button
    set_timing(16'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
               24'($urandom_range(1, 6)), 16'($urandom_range(1, 3)));
    random_ticks(60, 40);

    set_timing(16'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
               24'($urandom_range(0, 16)), 16'($urandom_range(0, 6)));
    random_ticks(120, 5);

    set_timing(16'($urandom_range(1, 3)), 8'($urandom_range(1, 5)),
               24'($urandom_range(1, 30)), 16'($urandom_range(1, 8)));
    random_ticks(70, 4);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
